@@ rtl/lpr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_pkg
// Shared constants and types of the LRU page replacement core.
// ----------------------------------------------------------------------------
package lpr_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;

    // Index / count width that covers the largest supported frame count (64)
    localparam int COUNT_W = 7;

    localparam int CAP_W   = 4;
    localparam int MISS_W  = 32;
    localparam int FIELD_W = 16;

    localparam logic [CAP_W-1:0]  CAP_RESET = 4'd8;
    localparam logic [MISS_W-1:0] MISS_MAX  = 32'hFFFF_FFFF;

    // Per-beat control broadcast from the top level to every cell
    typedef struct packed {
        logic               load;    // a reference beat is taken this cycle
        logic [COUNT_W-1:0] count;   // resident entries before this beat
        logic [COUNT_W-1:0] top;     // position that takes the new page
    } t_cell_ctrl;

endpackage

@@ rtl/lru_page_replacement_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement_core
// LRU page replacement over a row of stack cells, one page reference a beat.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                          | tuser             | tlast
//  s_axis   | in  | [15:0] page_number             | -                 | last_reference
//  m_axis   | out | [15:0] evicted_page,           | [0] page_hit,     | run_end
//           |     | [47:16] misses_so_far          | [1] evict_valid   |
//  cfg      | in  | i_cfg_wdata[3:0] frame_capacity, written when i_cfg_we
//
//  One reference per cycle unless the output stalls; its result shows in the next cycle.
//  The cycle is bounded by the match/shift ripple through the FRAMES cells.
//  Reset clears the resident count, miss count and output valid; capacity
//  returns to 8. Stack contents are not cleared, only the count marks them.
//  A stalled result holds the output register and blocks further input.
// ----------------------------------------------------------------------------
module lru_page_replacement_core
    import lpr_pkg::*;
#(
    parameter int FRAMES    = FRAMES_DEF,
    parameter int PAGE_BITS = PAGE_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [FIELD_W-1:0]   s_axis_tdata,   // [15:0] page_number
    input  logic                 s_axis_tlast,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [47:0]          m_axis_tdata,   // [15:0] evicted_page, [47:16] misses_so_far
    output logic [1:0]           m_axis_tuser,   // [0] page_hit, [1] evict_valid
    output logic                 m_axis_tlast,
    input  logic                 i_cfg_we,
    input  logic [CAP_W-1:0]     i_cfg_wdata
);

    localparam int CW = $clog2(FRAMES + 1);

    logic [CAP_W-1:0]     r_cap;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic [MISS_W-1:0]    r_miss;
    logic [MISS_W-1:0]    n_miss;
    logic [MISS_W-1:0]    w_miss_upd;

    logic                 r_out_valid;
    logic                 r_hit;
    logic                 r_evict;
    logic [FIELD_W-1:0]   r_victim;
    logic [MISS_W-1:0]    r_out_miss;
    logic                 r_last;

    logic                 w_accept;
    logic [PAGE_BITS-1:0] w_page;
    logic [7:0]           w_cnt8;
    logic [7:0]           w_cap8;
    logic                 w_full;
    logic                 w_hit;
    logic                 w_evict;
    logic [FRAMES-1:0]    w_match;
    t_cell_ctrl           w_ctrl;

    logic [PAGE_BITS-1:0] w_entry [FRAMES];
    logic [PAGE_BITS-1:0] w_next  [FRAMES];
    logic                 w_shift [FRAMES+1];

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_page = PAGE_BITS'(s_axis_tdata);

    // Capacity zero acts as one; above FRAMES it saturates at FRAMES
    assign w_cnt8 = 8'(r_count);
    assign w_cap8 = (r_cap == '0) ? 8'd1 : 8'(r_cap);
    assign w_full = (w_cnt8 >= w_cap8) || (w_cnt8 >= 8'(FRAMES));

    assign w_hit   = |w_match;
    assign w_evict = !w_hit && w_full;

    // Evicting seeds the shift token at the LRU end
    assign w_shift[0] = w_evict;

    genvar gi;
    generate
        for (gi = 0; gi < FRAMES; gi++) begin : g_cell
            if (gi == FRAMES - 1) begin : g_tail
                assign w_next[gi] = w_page;
            end else begin : g_body
                assign w_next[gi] = w_entry[gi+1];
            end
            lpr_cell #(
                .IDX       (gi),
                .PAGE_BITS (PAGE_BITS)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (w_ctrl),
                .i_page       (w_page),
                .i_next_entry (w_next[gi]),
                .i_shift      (w_shift[gi]),
                .o_shift      (w_shift[gi+1]),
                .o_match      (w_match[gi]),
                .o_entry      (w_entry[gi])
            );
        end
    endgenerate

    assign w_ctrl.load  = w_accept;
    assign w_ctrl.count = COUNT_W'(r_count);
    assign w_ctrl.top   = (w_hit || w_evict) ? COUNT_W'(r_count - 1'b1) : COUNT_W'(r_count);

    assign w_miss_upd = w_hit ? r_miss : ((r_miss == MISS_MAX) ? r_miss : r_miss + 1'b1);

    always_comb begin
        n_count = r_count;
        n_miss  = r_miss;
        if (w_accept) begin
            if (s_axis_tlast) begin
                n_count = '0;
                n_miss  = '0;
            end else begin
                n_miss = w_miss_upd;
                if (!w_hit && !w_full) begin
                    n_count = r_count + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap       <= CAP_RESET;
            r_count     <= '0;
            r_miss      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_count <= n_count;
            r_miss  <= n_miss;
            if (w_accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload: hold while the sink stalls
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_hit      <= w_hit;
            r_evict    <= w_evict;
            r_victim   <= w_evict ? FIELD_W'(w_entry[0]) : '0;
            r_out_miss <= w_miss_upd;
            r_last     <= s_axis_tlast;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_miss, r_victim};
    assign m_axis_tuser  = {r_evict, r_hit};
    assign m_axis_tlast  = r_last;

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_count) <= 32'(FRAMES)))
        else $error("resident count above frame count");

    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("hit and eviction reported together");

    a_run_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && s_axis_tlast) |=> (r_count == '0) && (r_miss == '0))
        else $error("state not cleared after last reference");

    a_miss_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[47:16] != '0))
        else $error("miss reported with zero miss count");

    a_shift_reach: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_hit || w_evict) |-> w_shift[FRAMES])
        else $error("shift token lost along the cell row");
`endif

endmodule

@@ rtl/lpr_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpr_cell
// One slot of the recency stack: compares its page, passes the shift token
// on to the next more-recent slot and takes its neighbour's page on a shift.
// ----------------------------------------------------------------------------
module lpr_cell
    import lpr_pkg::*;
#(
    parameter int IDX       = 0,
    parameter int PAGE_BITS = PAGE_BITS_DEF
) (
    input  logic                 i_clk,
    input  t_cell_ctrl           i_ctrl,
    input  logic [PAGE_BITS-1:0] i_page,
    input  logic [PAGE_BITS-1:0] i_next_entry,
    input  logic                 i_shift,
    output logic                 o_shift,
    output logic                 o_match,
    output logic [PAGE_BITS-1:0] o_entry
);

    localparam logic [COUNT_W-1:0] IDX_C = COUNT_W'(IDX);
    localparam logic [COUNT_W-1:0] NXT_C = COUNT_W'(IDX + 1);

    logic [PAGE_BITS-1:0] r_entry;
    logic [PAGE_BITS-1:0] n_entry;
    logic                 w_match;

    assign w_match = (IDX_C < i_ctrl.count) && (r_entry == i_page);
    // Everything at or above the removed slot moves one step toward LRU
    assign o_shift = i_shift || w_match;
    assign o_match = w_match;
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.load) begin
            if (i_ctrl.top == IDX_C) begin
                n_entry = i_page;
            end else if (o_shift && (NXT_C < i_ctrl.count)) begin
                n_entry = i_next_entry;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

@@ tb/tb_lru_page_replacement_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_page_replacement_core
// Self-checking bench for the LRU page replacement core: a directed table of
// page references, then phases of random reference streams under a range of
// frame capacities, with random stalls on both streams. Every result beat is
// compared field by field with a table expectation or an LRU stack model's output.
// ----------------------------------------------------------------------------
module tb_lru_page_replacement_core;
    import lpr_pkg::*;

    localparam int FRAMES      = FRAMES_DEF;
    localparam int LIMIT       = 500000;
    localparam int PHASES      = 15;
    localparam int PHASE_REFS  = 129;
    localparam int LONG_HOLD   = 80;
    localparam int DIR_ROWS    = 15;

    typedef struct packed {
        logic              hit;
        logic              evict;
        logic [15:0]       victim;
        logic [MISS_W-1:0] misses;
        logic              run_end;
    } t_lru_result;

    typedef struct packed {
        logic [15:0]  page;
        logic         last;
        logic         typed;   // want holds a literal expectation
        t_lru_result  want;
    } t_ref_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [FIELD_W-1:0] s_axis_tdata = '0;   // [15:0] page_number
    logic               s_axis_tlast = 1'b0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [47:0]        m_axis_tdata;        // [15:0] evicted_page, [47:16] misses_so_far
    logic [1:0]         m_axis_tuser;        // [0] page_hit, [1] evict_valid
    logic               m_axis_tlast;
    logic               i_cfg_we = 1'b0;
    logic [CAP_W-1:0]   i_cfg_wdata = '0;

    lru_page_replacement_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    // Model state: least recent page at index 0
    logic [15:0]       lru_stack [FRAMES];
    int                lru_depth  = 0;
    logic [MISS_W-1:0] run_misses = '0;
    logic [CAP_W-1:0]  frame_cap  = CAP_RESET;

    t_lru_result pending_q [$];
    t_lru_result got_want;
    int          errors = 0;
    int          cycles = 0;
    logic        calm = 1'b0;
    int          hold_requests = 0;
    int          hold_served   = 0;
    int          stall_left    = 0;

    t_ref_row dir_tab [DIR_ROWS] = '{
        '{16'h0000, 1'b0, 1'b1, '{1'b0, 1'b0, 16'h0000, 32'd1, 1'b0}},
        '{16'hFFFF, 1'b0, 1'b1, '{1'b0, 1'b0, 16'h0000, 32'd2, 1'b0}},
        '{16'h0000, 1'b0, 1'b1, '{1'b1, 1'b0, 16'h0000, 32'd2, 1'b0}},
        '{16'h0001, 1'b0, 1'b0, '0},
        '{16'h0002, 1'b0, 1'b0, '0},
        '{16'h0003, 1'b0, 1'b0, '0},
        '{16'h0004, 1'b0, 1'b0, '0},
        '{16'h0005, 1'b0, 1'b0, '0},
        '{16'h0006, 1'b0, 1'b0, '0},
        // all eight frames full: the oldest page goes
        '{16'h1234, 1'b0, 1'b1, '{1'b0, 1'b1, 16'hFFFF, 32'd9, 1'b0}},
        '{16'h0003, 1'b0, 1'b0, '0},
        '{16'h0000, 1'b1, 1'b0, '0},
        '{16'hAAAA, 1'b0, 1'b1, '{1'b0, 1'b0, 16'h0000, 32'd1, 1'b0}},
        '{16'h5555, 1'b0, 1'b0, '0},
        '{16'hAAAA, 1'b1, 1'b0, '0}
    };

    function automatic void drop_entry(input int pos);
        for (int i = pos; i < lru_depth - 1; i++)
            lru_stack[i] = lru_stack[i + 1];
        lru_depth--;
    endfunction

    function automatic t_lru_result lru_reference(input logic [15:0] page, input logic last);
        t_lru_result r;
        int          eff;
        int          pos;
        logic        found;
        r     = '0;
        found = 1'b0;
        pos   = 0;
        eff   = int'(frame_cap);
        if (eff == 0)
            eff = 1;
        if (eff > FRAMES)
            eff = FRAMES;
        for (int i = 0; i < lru_depth; i++) begin
            if (!found && lru_stack[i] == page) begin
                found = 1'b1;
                pos   = i;
            end
        end
        if (found) begin
            r.hit = 1'b1;
            drop_entry(pos);
        end else begin
            if (run_misses != MISS_MAX)
                run_misses++;
            // a lowered capacity only ever costs the single oldest page
            if (lru_depth >= eff) begin
                r.evict  = 1'b1;
                r.victim = lru_stack[0];
                drop_entry(0);
            end
        end
        if (lru_depth < FRAMES) begin
            lru_stack[lru_depth] = page;
            lru_depth++;
        end
        r.misses  = run_misses;
        r.run_end = last;
        if (last) begin
            lru_depth  = 0;
            run_misses = '0;
        end
        return r;
    endfunction

    // Present one reference beat and hold it until taken
    task automatic put_ref(input logic [15:0] page, input logic last, input int gap,
                           input logic typed, input t_lru_result want);
        t_lru_result r;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= page;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        r = lru_reference(page, last);
        if (typed)
            pending_q = {pending_q, want};
        else
            pending_q = {pending_q, r};
    endtask

    task automatic drain;
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        drain();
        repeat (3) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        frame_cap   = value;
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch: expected %0h, got %0h", $time, what, want, got);
            errors++;
        end
    endtask

    // Result side: random back-pressure plus the long hold-off on request
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served++;
            stall_left = LONG_HOLD;
        end
        if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 6);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_q.size() == 0) begin
                $display("%0t ns: unexpected result beat: tuser %b tdata %h tlast %b",
                         $time, m_axis_tuser, m_axis_tdata, m_axis_tlast);
                errors++;
            end else begin
                got_want = pending_q[0];
                pending_q.delete(0);
                check_field("page_hit", 32'(got_want.hit), 32'(m_axis_tuser[0]));
                check_field("evict_valid", 32'(got_want.evict), 32'(m_axis_tuser[1]));
                check_field("evicted_page", 32'(got_want.victim), 32'(m_axis_tdata[15:0]));
                check_field("misses_so_far", got_want.misses, m_axis_tdata[47:16]);
                check_field("run_end", 32'(got_want.run_end), 32'(m_axis_tlast));
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        logic [15:0]      pool [16];
        int               pool_n;
        logic [15:0]      page;
        logic             last;
        int               gap;
        logic [CAP_W-1:0] cap;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIR_ROWS; k++)
            put_ref(dir_tab[k].page, dir_tab[k].last, 0, dir_tab[k].typed, dir_tab[k].want);
        s_axis_tvalid <= 1'b0;

        for (int ph = 0; ph < PHASES; ph++) begin
            // zero and above-range values first, then a drop to one frame mid-run
            case (ph)
                0:       cap = 4'd0;
                1:       cap = 4'd15;
                2:       cap = 4'd1;
                3:       cap = 4'd8;
                default: cap = CAP_W'($urandom_range(0, 15));
            endcase
            write_capacity(cap);
            calm = (ph >= PHASES - 2);
            pool_n = $urandom_range(1, 12);
            for (int j = 0; j < pool_n; j++)
                pool[j] = 16'($urandom);
            if (ph == 4) begin
                pool[0] = 16'h0000;
                pool[pool_n - 1] = 16'hFFFF;
            end
            for (int n = 0; n < PHASE_REFS; n++) begin
                if (ph == 2 && n == 10)
                    hold_requests++;
                if (ph == 4 && n == 60) begin
                    s_axis_tvalid <= 1'b0;
                    drain();
                end
                if ($urandom_range(0, 9) < 8)
                    page = pool[$urandom_range(0, pool_n - 1)];
                else
                    page = 16'($urandom);
                // keep the run open across the next capacity write
                last = (ph != 1) && ($urandom_range(0, 24) == 0);
                gap  = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 7) : 0;
                put_ref(page, last, gap, 1'b0, '0);
            end
            s_axis_tvalid <= 1'b0;
        end

        drain();
        repeat (5) @(posedge i_clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
